/* design/ctf_pkg.sv */
// ----------------------------------------------------------------------------
// Palette texture fetch: shared definitions
// Store geometry, item layouts, mode and status codes, address helpers.
// ----------------------------------------------------------------------------
package ctf_pkg;

  localparam int unsigned STORE_COLUMNS = 1024;
  localparam int unsigned STORE_ROWS    = 512;
  localparam int unsigned STORE_DEPTH   = STORE_COLUMNS * STORE_ROWS;
  localparam int unsigned ADDR_W        = $clog2(STORE_DEPTH);
  // Each entry is a written mark above a 16-bit word.
  localparam int unsigned ENTRY_W       = 17;
  // Wide enough for any computed column or row and for the store limits.
  localparam int unsigned COORD_W       = 12;

  localparam logic [1:0] MODE_SAMPLE = 2'd0;
  localparam logic [1:0] MODE_WR_TEX = 2'd1;
  localparam logic [1:0] MODE_WR_PAL = 2'd2;

  localparam logic [1:0] STATUS_OPAQUE      = 2'd0;
  localparam logic [1:0] STATUS_TRANSPARENT = 2'd1;
  localparam logic [1:0] STATUS_MISSING     = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] page_word;
    logic [15:0] palette_word;
    logic [7:0]  tex_u;
    logic [7:0]  tex_v;
    logic [9:0]  write_col;
    logic [8:0]  write_row;
    logic [15:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0] sample_status;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic stage2;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic is_sample;
  } dp_sts_t;

  function automatic logic in_store(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
    return (col < COORD_W'(STORE_COLUMNS)) && (row < COORD_W'(STORE_ROWS));
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(logic [COORD_W-1:0] col,
                                                   logic [COORD_W-1:0] row);
    logic [31:0] lin;
    lin = 32'(row) * 32'(STORE_COLUMNS) + 32'(col);
    return lin[ADDR_W-1:0];
  endfunction

  function automatic logic [7:0] widen5(logic [4:0] c);
    return {c, c[4:2]};
  endfunction

endpackage

/* design/ctf_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One access per cycle; read data is registered and holds between reads.
// ----------------------------------------------------------------------------
module ctf_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/ctf_ctrl.sv */
// ----------------------------------------------------------------------------
// Palette texture fetch: controller
// Sequences the clearing pass, item acceptance, the two store reads of a
// sample and the hand-over to the output register.
// ----------------------------------------------------------------------------
module ctf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              out_stall_i,
  input  ctf_pkg::dp_sts_t  sts_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  output ctf_pkg::ctl_cmd_t cmd_o
);
  import ctf_pkg::*;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_TEX   = 2'd2;
  localparam logic [1:0] ST_PAL   = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;
  ctl_cmd_t   cmd;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.accept = 1'b1;
          // Writes and unused modes finish in the cycle they are taken.
          if (sts_i.is_sample) begin
            state_d = ST_TEX;
          end
        end
      end
      ST_TEX: begin
        cmd.stage2 = 1'b1;
        state_d    = ST_PAL;
      end
      ST_PAL: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_d      = ST_IDLE;
        end
      end
    endcase
  end

  assign out_valid_d = cmd.out_load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clear |-> !cmd.accept && in_stall_o)
    else $error("transaction accepted during clearing pass");

  a_sample_reads_palette: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.accept && sts_i.is_sample |=> cmd.stage2)
    else $error("palette read did not follow sample acceptance");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("output register overwritten while stalled");

  a_load_shows_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |=> out_valid_o)
    else $error("loaded result not presented");
`endif

endmodule

/* design/ctf_dpath.sv */
// ----------------------------------------------------------------------------
// Palette texture fetch: datapath
// Address decode, texture and palette stores, index extraction and colour
// expansion, and the output register.
// ----------------------------------------------------------------------------
module ctf_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ctf_pkg::in_item_t  in_data_i,
  input  ctf_pkg::ctl_cmd_t  cmd_i,
  output ctf_pkg::dp_sts_t   sts_o,
  output ctf_pkg::out_item_t out_data_o
);
  import ctf_pkg::*;

  logic [ADDR_W-1:0]  clr_q;

  logic [1:0]         depth;
  logic               bpp8;
  logic [COORD_W-1:0] word_x, word_y;
  logic [1:0]         texel;
  logic               tex_ok;
  logic [ADDR_W-1:0]  tex_addr;

  logic               wr_ok;
  logic [ADDR_W-1:0]  wr_addr;
  logic               wr_tex, wr_pal;

  logic               miss1_q, bpp8_q;
  logic [1:0]         texel_q;
  logic [15:0]        pal_q;

  logic [ENTRY_W-1:0] tex_rdata, pal_rdata;
  logic [7:0]         index;
  logic [COORD_W-1:0] pcol, prow;
  logic               pal_ok;
  logic [ADDR_W-1:0]  pal_addr;
  logic               miss2_q;

  logic               tex_en, tex_we, pal_en, pal_we;
  logic [ADDR_W-1:0]  tex_ram_addr, pal_ram_addr;
  logic [ENTRY_W-1:0] fill_data;

  logic               miss;
  logic [15:0]        colour;
  out_item_t          out_d, out_q;

  // Clearing pass counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + ADDR_W'(1);
    end
  end

  assign sts_o.clear_last = (clr_q == ADDR_W'(STORE_DEPTH - 1));
  assign sts_o.is_sample  = (in_data_i.mode == MODE_SAMPLE);

  // Texture word address of a sample.
  assign depth  = in_data_i.page_word[8:7];
  assign bpp8   = (depth == 2'd1);
  assign word_x = {2'b00, in_data_i.page_word[3:0], 6'b0}
                + (bpp8 ? {5'b0, in_data_i.tex_u[7:1]} : {6'b0, in_data_i.tex_u[7:2]});
  assign word_y = {3'b000, in_data_i.page_word[4], in_data_i.tex_v};
  assign texel  = bpp8 ? {1'b0, in_data_i.tex_u[0]} : in_data_i.tex_u[1:0];
  assign tex_ok = (depth[1] == 1'b0) && in_store(word_x, word_y);
  assign tex_addr = store_addr(word_x, word_y);

  // Address of a write item.
  assign wr_ok   = in_store({2'b00, in_data_i.write_col}, {3'b000, in_data_i.write_row});
  assign wr_addr = store_addr({2'b00, in_data_i.write_col}, {3'b000, in_data_i.write_row});
  assign wr_tex  = cmd_i.accept && (in_data_i.mode == MODE_WR_TEX) && wr_ok;
  assign wr_pal  = cmd_i.accept && (in_data_i.mode == MODE_WR_PAL) && wr_ok;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      miss1_q <= !tex_ok;
      bpp8_q  <= bpp8;
      texel_q <= texel;
      pal_q   <= in_data_i.palette_word;
    end
  end

  // Palette index from the texture word, then the palette entry address.
  always_comb begin
    if (bpp8_q) begin
      index = texel_q[0] ? tex_rdata[15:8] : tex_rdata[7:0];
    end else begin
      unique case (texel_q)
        2'd0: index = {4'b0, tex_rdata[3:0]};
        2'd1: index = {4'b0, tex_rdata[7:4]};
        2'd2: index = {4'b0, tex_rdata[11:8]};
        2'd3: index = {4'b0, tex_rdata[15:12]};
      endcase
    end
  end

  assign pcol     = {2'b00, pal_q[5:0], 4'b0} + {4'b0, index};
  assign prow     = {2'b00, pal_q[15:6]};
  assign pal_ok   = in_store(pcol, prow);
  assign pal_addr = store_addr(pcol, prow);

  always_ff @(posedge clk_i) begin
    if (cmd_i.stage2) begin
      miss2_q <= miss1_q || !tex_rdata[ENTRY_W-1] || !pal_ok;
    end
  end

  // Store ports: the clearing pass writes unwritten marks to both stores.
  assign fill_data    = cmd_i.clear ? '0 : {1'b1, in_data_i.write_data};

  assign tex_en       = cmd_i.clear || wr_tex
                      || (cmd_i.accept && sts_o.is_sample && tex_ok);
  assign tex_we       = cmd_i.clear || wr_tex;
  assign tex_ram_addr = cmd_i.clear ? clr_q : (wr_tex ? wr_addr : tex_addr);

  assign pal_en       = cmd_i.clear || wr_pal || (cmd_i.stage2 && pal_ok && !miss1_q);
  assign pal_we       = cmd_i.clear || wr_pal;
  assign pal_ram_addr = cmd_i.clear ? clr_q : (wr_pal ? wr_addr : pal_addr);

  ctf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_tex_ram (
    .clk_i   (clk_i),
    .en_i    (tex_en),
    .we_i    (tex_we),
    .addr_i  (tex_ram_addr),
    .wdata_i (fill_data),
    .rdata_o (tex_rdata)
  );

  ctf_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STORE_DEPTH)
  ) u_pal_ram (
    .clk_i   (clk_i),
    .en_i    (pal_en),
    .we_i    (pal_we),
    .addr_i  (pal_ram_addr),
    .wdata_i (fill_data),
    .rdata_o (pal_rdata)
  );

  // Colour decode. Bit 15 alone still counts as a non-zero colour.
  assign miss   = miss2_q || !pal_rdata[ENTRY_W-1];
  assign colour = pal_rdata[15:0];

  always_comb begin
    out_d = '0;
    if (miss) begin
      out_d.sample_status = STATUS_MISSING;
    end else if (colour == 16'd0) begin
      out_d.sample_status = STATUS_TRANSPARENT;
    end else begin
      out_d.sample_status = STATUS_OPAQUE;
      out_d.red           = widen5(colour[4:0]);
      out_d.green         = widen5(colour[9:5]);
      out_d.blue          = widen5(colour[14:10]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

/* design/clut_texture_fetch.sv */
// ----------------------------------------------------------------------------
// Palette texture fetch
// 4 and 8 bpp palette texture sampling over texture and palette word stores.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  in       input      in_valid_i / in_stall_o   in_data_i  (ctf_pkg::in_item_t)
//  out      output     out_valid_o / out_stall_i out_data_o (ctf_pkg::out_item_t)
//
// A write transaction is taken in its accepting cycle. A sample stalls the input
// while the accepting cycle starts the texture store read, the next the dependent
// palette store read, and the PAL state then loads the output register.
// After reset a clearing pass marks every entry of both stores unwritten, with
// in_stall_o high throughout. A result waits in the output register while
// out_stall_i is high; a following write is still taken, and a following sample
// is taken but keeps in_stall_o high after its palette read until the register
// frees.
// ----------------------------------------------------------------------------
module clut_texture_fetch (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  ctf_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output ctf_pkg::out_item_t out_data_o
);
  import ctf_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  ctf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  ctf_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

/* dv/clut_texture_fetch_checker.sv */
// ----------------------------------------------------------------------------
// Palette texture fetch checker
// Watches both channels of the block, keeps its own copy of the texture and
// palette stores, predicts the result of every sample transaction and compares
// each returned result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module clut_texture_fetch_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  ctf_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  ctf_pkg::out_item_t out_data_i,
  output int unsigned        errors_o,
  output int unsigned        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import ctf_pkg::*;

  // Only entries that exist have been written.
  logic [15:0] texture_words[int];
  logic [15:0] palette_words[int];
  out_item_t   expected_texels[$];
  int unsigned fails;

  function automatic int word_slot(int unsigned col, int unsigned row);
    if (col >= STORE_COLUMNS || row >= STORE_ROWS) return -1;
    return int'(row * STORE_COLUMNS + col);
  endfunction

  function automatic logic [7:0] stretch5(logic [4:0] c);
    return (8'(c) << 3) | (8'(c) >> 2);
  endfunction

  function automatic out_item_t predict_texel(in_item_t it);
    out_item_t   res;
    int unsigned bpp, texels_in_word, word_x, word_y, texel, index, pal_x, pal_y;
    int          slot;
    logic [15:0] word, colour;
    res = '0;
    res.sample_status = STATUS_MISSING;
    // Depth codes 2 and 3 both have the upper depth bit set: 15 bpp.
    if (it.page_word[8]) return res;
    bpp            = it.page_word[7] ? 8 : 4;
    texels_in_word = 16 / bpp;
    word_x   = 64 * it.page_word[3:0] + it.tex_u / texels_in_word;
    word_y   = (it.page_word[4] ? 256 : 0) + it.tex_v;
    texel    = it.tex_u % texels_in_word;
    slot     = word_slot(word_x, word_y);
    if (slot < 0 || !texture_words.exists(slot)) return res;
    word   = texture_words[slot];
    index  = (word >> (texel * bpp)) & ((1 << bpp) - 1);
    pal_x  = 16 * it.palette_word[5:0] + index;
    pal_y  = it.palette_word[15:6];
    slot   = word_slot(pal_x, pal_y);
    if (slot < 0 || !palette_words.exists(slot)) return res;
    colour = palette_words[slot];
    if (colour == 16'h0000) begin
      res.sample_status = STATUS_TRANSPARENT;
      return res;
    end
    // Bit 15 alone still counts as a colour, giving opaque black.
    res.sample_status = STATUS_OPAQUE;
    res.red   = stretch5(colour[4:0]);
    res.green = stretch5(colour[9:5]);
    res.blue  = stretch5(colour[14:10]);
    return res;
  endfunction

  function automatic int unsigned field_differs(string name, logic [7:0] want,
                                                logic [7:0] got);
    if (got === want) return 0;
    $error("%s: expected %0d, got %0d", name, want, got);
    return 1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    int        slot;
    if (!rst_ni) begin
      texture_words.delete();
      palette_words.delete();
      expected_texels.delete();
      fails      = 0;
      errors_o  <= 0;
      pending_o <= 0;
    end else begin
      // A result seen at this edge always belongs to an earlier sample.
      if (out_valid_i && !out_stall_i) begin
        if (expected_texels.size() == 0) begin
          $error("result transaction with no sample waiting: status %0d",
                 out_data_i.sample_status);
          fails++;
        end else begin
          want = expected_texels.pop_front();
          fails += field_differs("sample_status", 8'(want.sample_status),
                                 8'(out_data_i.sample_status));
          fails += field_differs("red", want.red, out_data_i.red);
          fails += field_differs("green", want.green, out_data_i.green);
          fails += field_differs("blue", want.blue, out_data_i.blue);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        slot = word_slot(in_data_i.write_col, in_data_i.write_row);
        case (in_data_i.mode)
          MODE_SAMPLE: begin
            expected_texels = {expected_texels, predict_texel(in_data_i)};
          end
          MODE_WR_TEX: begin
            if (slot >= 0) texture_words[slot] = in_data_i.write_data;
          end
          MODE_WR_PAL: begin
            if (slot >= 0) palette_words[slot] = in_data_i.write_data;
          end
          default: begin
          end
        endcase
      end
      errors_o  <= fails;
      pending_o <= expected_texels.size();
    end
  end

endmodule

/* dv/clut_texture_fetch_tb.sv */
// ----------------------------------------------------------------------------
// Palette texture fetch testbench
// Drives directed and random write and sample transactions with random gaps
// and output stalls; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module clut_texture_fetch_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ctf_pkg::*;

  localparam logic [1:0]  MODE_IGNORED = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 600;
  // The clearing pass after reset is the longest quiet stretch of a good run.
  localparam int unsigned QUIET_LIMIT  = 3 * STORE_DEPTH;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_stall_i;
  out_item_t   out_data_o;
  int unsigned check_errors;
  int unsigned pending_results;
  int unsigned items_sent = 0;
  int unsigned quiet_cycles = 0;
  logic        calm = 1'b0;

  clut_texture_fetch DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  clut_texture_fetch_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .errors_o    (check_errors),
    .pending_o   (pending_results)
  );

  always #5 clk_i = ~clk_i;

  // Alternate between stretches with random gaps and stretches with none.
  initial begin
    forever begin
      repeat ($urandom_range(50, 400)) @(posedge clk_i);
      calm <= ~calm;
    end
  end

  function automatic int unsigned pick_wait();
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  function automatic in_item_t noise_item();
    logic [95:0] bits;
    bits = {$urandom(), $urandom(), $urandom()};
    return bits[$bits(in_item_t)-1:0];
  endfunction

  function automatic in_item_t make_item(logic [1:0] mode, logic [15:0] page,
                                         logic [15:0] pal, logic [7:0] u,
                                         logic [7:0] v, logic [9:0] col,
                                         logic [8:0] row, logic [15:0] data);
    in_item_t it;
    it.mode         = mode;
    it.page_word    = page;
    it.palette_word = pal;
    it.tex_u        = u;
    it.tex_v        = v;
    it.write_col    = col;
    it.write_row    = row;
    it.write_data   = data;
    return it;
  endfunction

  // Valid stays high after acceptance until the next transaction decides
  // whether to leave a gap, so it is never lowered and raised in one step.
  task automatic push_item(input in_item_t item);
    int unsigned gap;
    gap = pick_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (item.mode != MODE_IGNORED) items_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_results != 0);
    @(posedge clk_i);
  endtask

  // Writes the texture word and palette entry that a sample will hit, most of
  // the time, then sends the sample itself.
  task automatic play_scene();
    in_item_t    it;
    logic [15:0] page, pal, word, colour;
    logic [7:0]  u, v;
    int unsigned pick, bpp, word_col, word_row, texel, index, pal_col, pal_row;
    page = $urandom();
    pal  = $urandom();
    u    = $urandom();
    v    = $urandom();
    pick = $urandom_range(0, 9);
    page[8:7] = (pick < 4) ? 2'd0 : (pick < 8) ? 2'd1 : 2'(pick - 6);
    if ($urandom_range(0, 7) != 0) pal[15] = 1'b0;
    bpp      = page[7] ? 8 : 4;
    word_col = 64 * page[3:0] + u / (16 / bpp);
    word_row = (page[4] ? 256 : 0) + v;
    texel    = u % (16 / bpp);
    index    = $urandom_range(0, (1 << bpp) - 1);
    word     = $urandom();
    if (bpp == 4) word[texel*4 +: 4] = 4'(index);
    else word[texel*8 +: 8] = 8'(index);
    if (word_col < STORE_COLUMNS && $urandom_range(0, 9) != 0) begin
      it = noise_item();
      it.mode       = MODE_WR_TEX;
      it.write_col  = 10'(word_col);
      it.write_row  = 9'(word_row);
      it.write_data = word;
      push_item(it);
    end
    pal_col = 16 * pal[5:0] + index;
    pal_row = pal[15:6];
    if (pal_col < STORE_COLUMNS && pal_row < STORE_ROWS &&
        $urandom_range(0, 9) != 0) begin
      pick   = $urandom_range(0, 9);
      colour = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'h8000 : 16'($urandom());
      it = noise_item();
      it.mode       = MODE_WR_PAL;
      it.write_col  = 10'(pal_col);
      it.write_row  = 9'(pal_row);
      it.write_data = colour;
      push_item(it);
    end
    it = noise_item();
    it.mode         = MODE_SAMPLE;
    it.page_word    = page;
    it.palette_word = pal;
    it.tex_u        = u;
    it.tex_v        = v;
    push_item(it);
  endtask

  initial begin
    int unsigned stall_left;
    stall_left  = 0;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) stall_left = pick_wait();
      else if (out_valid_o && stall_left > 0) stall_left--;
      out_stall_i <= (stall_left > 0);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned target, halfway;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Nothing written yet, so the first sample misses.
    push_item(make_item(MODE_SAMPLE, 16'h0000, 16'h0000, 8'd0, 8'd0, 10'd0, 9'd0, 16'h0));
    push_item(make_item(MODE_WR_TEX, 16'h0, 16'h0, 8'd0, 8'd0, 10'd0, 9'd0, 16'h3A10));
    // Texture word present, palette entry not.
    push_item(make_item(MODE_SAMPLE, 16'h0000, 16'h0000, 8'd0, 8'd0, 10'd0, 9'd0, 16'h0));
    push_item(make_item(MODE_WR_PAL, 16'h0, 16'h0, 8'd0, 8'd0, 10'd0, 9'd0, 16'h0000));
    push_item(make_item(MODE_SAMPLE, 16'h0000, 16'h0000, 8'd0, 8'd0, 10'd0, 9'd0, 16'h0));
    push_item(make_item(MODE_WR_PAL, 16'h0, 16'h0, 8'd0, 8'd0, 10'd1, 9'd0, 16'h8000));
    push_item(make_item(MODE_SAMPLE, 16'h0000, 16'h0000, 8'd1, 8'd0, 10'd0, 9'd0, 16'h0));
    push_item(make_item(MODE_WR_PAL, 16'h0, 16'h0, 8'd0, 8'd0, 10'd10, 9'd0, 16'h7FFF));
    push_item(make_item(MODE_SAMPLE, 16'h0000, 16'h0000, 8'd2, 8'd0, 10'd0, 9'd0, 16'h0));
    // Two writes to one palette entry: the second must be the one read back.
    push_item(make_item(MODE_WR_PAL, 16'h0, 16'h0, 8'd0, 8'd0, 10'd3, 9'd0, 16'h1234));
    push_item(make_item(MODE_WR_PAL, 16'h0, 16'h0, 8'd0, 8'd0, 10'd3, 9'd0, 16'h4321));
    push_item(make_item(MODE_SAMPLE, 16'h0000, 16'h0000, 8'd3, 8'd0, 10'd0, 9'd0, 16'h0));
    // Both 15 bpp depth codes.
    push_item(make_item(MODE_SAMPLE, 16'h0100, 16'h0000, 8'd0, 8'd0, 10'd0, 9'd0, 16'h0));
    push_item(make_item(MODE_SAMPLE, 16'h0180, 16'h0000, 8'd0, 8'd0, 10'd0, 9'd0, 16'h0));
    // 8 bpp from the last page column runs past the store.
    push_item(make_item(MODE_SAMPLE, 16'h008F, 16'h0000, 8'hFF, 8'd0, 10'd0, 9'd0, 16'h0));
    // The far corner of both stores.
    push_item(make_item(MODE_WR_TEX, 16'h0, 16'h0, 8'd0, 8'd0, 10'd1023, 9'd511, 16'hF000));
    push_item(make_item(MODE_WR_PAL, 16'h0, 16'h0, 8'd0, 8'd0, 10'd1023, 9'd511, 16'hFFFF));
    push_item(make_item(MODE_SAMPLE, 16'h001F, 16'h7FFF, 8'hFF, 8'hFF, 10'd0, 9'd0, 16'h0));
    // Palette row, then palette column, beyond the store.
    push_item(make_item(MODE_SAMPLE, 16'h001F, 16'hFFFF, 8'hFF, 8'hFF, 10'd0, 9'd0, 16'h0));
    push_item(make_item(MODE_SAMPLE, 16'h0080, 16'h003F, 8'd0, 8'd0, 10'd0, 9'd0, 16'h0));
    push_item(make_item(MODE_IGNORED, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 10'd1023, 9'd511,
                        16'hFFFF));

    target  = items_sent + RANDOM_ITEMS;
    halfway = items_sent + RANDOM_ITEMS / 2;
    drain_results();
    while (items_sent < target) begin
      if ($urandom_range(0, 5) == 0) push_item(noise_item());
      else play_scene();
      if (items_sent >= halfway && halfway != 0) begin
        drain_results();
        halfway = 0;
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    if (check_errors == 0 && pending_results == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
